// ===== hw/rtl/udm_pkg.sv =====
// ----------------------------------------------------------------------------
// udm_pkg
// Shared types for the unsigned division magic generator: sequencer states
// and the control word of the shared add/subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

package udm_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_TZ,
        ST_PREP,
        ST_DIV,
        ST_STEP,
        ST_TEST,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        ALU_DEC,   // d - 1
        ALU_DIV,   // {r, bit} - d
        ALU_DMR,   // d - r - 1
        ALU_INC    // q + 1
    } alu_op_t;

    typedef struct packed {
        alu_op_t op;
        logic    bit_in;
    } alu_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/udm_alu.sv =====
// ----------------------------------------------------------------------------
// udm_alu
// Shared adder of the generator: selects operands for the restoring divide
// and exponent steps, the power-of-two test, the bound test and the final
// multiplier increment.
// ----------------------------------------------------------------------------
`default_nettype none

module udm_alu #(
    parameter int DIVISOR_WIDTH = 32
) (
    input  wire udm_pkg::alu_ctrl_t        ctrl,
    input  wire logic [DIVISOR_WIDTH-1:0]  d,
    input  wire logic [DIVISOR_WIDTH-1:0]  r,
    input  wire logic [DIVISOR_WIDTH-1:0]  q,
    output logic [DIVISOR_WIDTH+1:0]       sum
);
    import udm_pkg::*;

    localparam int W  = DIVISOR_WIDTH;
    localparam int AW = W + 2;

    logic [W:0] opa;
    logic [W:0] opb;
    logic       cin;

    always_comb begin
        case (ctrl.op)
            ALU_DEC: begin
                opa = {1'b0, d};
                opb = '1;
                cin = 1'b0;
            end
            ALU_DIV: begin
                opa = {r, ctrl.bit_in};
                opb = ~{1'b0, d};
                cin = 1'b1;
            end
            ALU_DMR: begin
                opa = {1'b0, d};
                opb = ~{1'b0, r};
                cin = 1'b0;
            end
            ALU_INC: begin
                opa = {1'b0, q};
                opb = '0;
                cin = 1'b1;
            end
            default: begin
                opa = '0;
                opb = '0;
                cin = 1'b0;
            end
        endcase
    end

    // top bit is the carry: set when no borrow on the subtracting ops
    assign sum = {1'b0, opa} + {1'b0, opb} + AW'(cin);

endmodule

`default_nettype wire

// ===== hw/rtl/unsigned_division_magic_generator.sv =====
// ----------------------------------------------------------------------------
// unsigned_division_magic_generator
// Multiply-shift recipe for unsigned division by a constant: multiplier,
// pre-shift, post-shift and increment flag, or an error flag.
// ----------------------------------------------------------------------------
//  channel   dir   handshake          words
//  s_        in    s_valid/s_ready    s_divisor, s_dividend_bits
//  m_        out   m_valid/m_ready    m_multiplier, m_dividend_shift, m_product_shift,
//                                     m_add_increment, m_bad_divisor
//
//  the sequencer checks the divisor, strips its trailing zeros and divides,
//  then alternates step and test until the bound test holds or the exponent
//  runs out; a divisor rejected at the check, or one whose trailing zeros use
//  up the dividend bits, gives an error. All of it runs through one shared adder.
//  s_ready is high only while the sequencer idles; one word at a time.
//  a result held by m_ready low stalls only the final write of the next word.
//  reset (aresetn low, synchronous) returns to idle and drops m_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module unsigned_division_magic_generator #(
    parameter int DIVISOR_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_divisor,
    input  wire logic [5:0]  s_dividend_bits,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_multiplier,
    output logic [4:0]       m_dividend_shift,
    output logic [4:0]       m_product_shift,
    output logic             m_add_increment,
    output logic             m_bad_divisor
);
    import udm_pkg::*;

    localparam int W  = DIVISOR_WIDTH;
    localparam int CW = $clog2(W + 1);
    localparam int SW = $clog2(2 * W);
    localparam int KW = $clog2(W);

    state_t state_reg, state_next;

    logic [W-1:0]  d_reg, d_next;
    logic [5:0]    bits_reg, bits_next;
    logic [CW-1:0] pre_reg, pre_next;
    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  t_reg, t_next;
    logic [CW-1:0] clog_reg, clog_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] e_reg, e_next;
    logic [SW-1:0] s_reg, s_next;
    logic [W-1:0]  hmask_reg, hmask_next;
    logic [W-1:0]  down_mul_reg, down_mul_next;
    logic [CW-1:0] down_exp_reg, down_exp_next;
    logic          have_down_reg, have_down_next;
    logic          bad_reg, bad_next;

    logic          m_valid_reg, m_valid_next;
    logic [31:0]   m_multiplier_reg, m_multiplier_next;
    logic [4:0]    m_dividend_shift_reg, m_dividend_shift_next;
    logic [4:0]    m_product_shift_reg, m_product_shift_next;
    logic          m_add_increment_reg, m_add_increment_next;
    logic          m_bad_divisor_reg, m_bad_divisor_next;

    alu_ctrl_t     alu_ctrl;
    logic [W+1:0]  alu_sum;

    logic          div_bit;
    logic [CW-1:0] bits_cw;
    logic [CW-1:0] beff;
    logic [SW-1:0] extra;
    logic          input_bad;
    logic          pre_exhaust;
    logic          step_carry;
    logic [W-1:0]  step_diff;
    logic [W-1:0]  r_shift;
    logic          test_hit;
    logic          s_over;
    logic [W-1:0]  onehot;
    logic          r_le;
    logic          up_ok;
    logic          out_wr;
    logic          loop_done;

    udm_alu #(.DIVISOR_WIDTH(W)) u_alu (
        .ctrl (alu_ctrl),
        .d    (d_reg),
        .r    (r_reg),
        .q    (q_reg),
        .sum  (alu_sum)
    );

    assign div_bit     = (state_reg == ST_DIV) && (cnt_reg == '0);
    assign bits_cw     = CW'(bits_reg);
    assign beff        = bits_cw - pre_reg;
    assign extra       = SW'(W) - SW'(beff);
    assign input_bad   = (d_reg == '0) || ((d_reg & alu_sum[W-1:0]) == '0)
                         || (bits_reg == '0) || ({1'b0, bits_reg} > 7'(W));
    assign pre_exhaust = pre_reg >= bits_cw;
    assign step_carry  = alu_sum[W+1];
    assign step_diff   = alu_sum[W-1:0];
    assign r_shift     = {r_reg[W-2:0], div_bit};
    // d - r <= 2^s, tested as (d - r - 1) having no bit at or above s
    assign test_hit    = (alu_sum[W-1:0] & hmask_reg) == '0;
    assign s_over      = s_reg >= SW'(clog_reg);
    assign loop_done   = s_over || test_hit;
    assign onehot      = hmask_reg & ~(hmask_reg << 1);
    assign r_le        = ((r_reg & hmask_reg) == '0) || (r_reg == onehot);
    assign up_ok       = e_reg < clog_reg;
    assign out_wr      = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = input_bad ? ST_FINISH : ST_TZ;
            end
            ST_TZ: begin
                if (d_reg[0]) state_next = ST_PREP;
            end
            ST_PREP: begin
                state_next = pre_exhaust ? ST_FINISH : ST_DIV;
            end
            ST_DIV: begin
                if (cnt_reg == KW'(W - 1)) state_next = ST_STEP;
            end
            ST_STEP: begin
                state_next = ST_TEST;
            end
            ST_TEST: begin
                state_next = loop_done ? ST_FINISH : ST_STEP;
            end
            ST_FINISH: begin
                if (out_wr) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        alu_ctrl.bit_in = div_bit;
        s_ready         = 1'b0;
        case (state_reg)
            ST_IDLE:   begin alu_ctrl.op = ALU_DIV; s_ready = 1'b1; end
            ST_CHECK:  alu_ctrl.op = ALU_DEC;
            ST_DIV:    alu_ctrl.op = ALU_DIV;
            ST_STEP:   alu_ctrl.op = ALU_DIV;
            ST_TEST:   alu_ctrl.op = ALU_DMR;
            ST_FINISH: alu_ctrl.op = ALU_INC;
            default:   alu_ctrl.op = ALU_DIV;
        endcase
    end

    // datapath
    always_comb begin
        d_next                = d_reg;
        bits_next             = bits_reg;
        pre_next              = pre_reg;
        q_next                = q_reg;
        r_next                = r_reg;
        t_next                = t_reg;
        clog_next             = clog_reg;
        cnt_next              = cnt_reg;
        e_next                = e_reg;
        s_next                = s_reg;
        hmask_next            = hmask_reg;
        down_mul_next         = down_mul_reg;
        down_exp_next         = down_exp_reg;
        have_down_next        = have_down_reg;
        bad_next              = bad_reg;
        m_multiplier_next     = m_multiplier_reg;
        m_dividend_shift_next = m_dividend_shift_reg;
        m_product_shift_next  = m_product_shift_reg;
        m_add_increment_next  = m_add_increment_reg;
        m_bad_divisor_next    = m_bad_divisor_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    d_next    = W'(s_divisor);
                    bits_next = s_dividend_bits;
                    pre_next  = '0;
                    bad_next  = 1'b0;
                end
            end
            ST_CHECK: begin
                if (input_bad) bad_next = 1'b1;
            end
            ST_TZ: begin
                // strip trailing zeros, one a cycle
                if (!d_reg[0]) begin
                    d_next   = d_reg >> 1;
                    pre_next = pre_reg + 1'b1;
                end
            end
            ST_PREP: begin
                if (pre_exhaust) begin
                    bad_next = 1'b1;
                end else begin
                    q_next         = '0;
                    r_next         = '0;
                    t_next         = d_reg;
                    clog_next      = '0;
                    cnt_next       = '0;
                    e_next         = '0;
                    s_next         = extra;
                    hmask_next     = {W{1'b1}} << extra;
                    have_down_next = 1'b0;
                end
            end
            ST_DIV, ST_STEP: begin
                if (step_carry) begin
                    q_next = {q_reg[W-2:0], 1'b1};
                    r_next = step_diff;
                end else begin
                    q_next = {q_reg[W-2:0], 1'b0};
                    r_next = r_shift;
                end
                // bit length of the divisor counted alongside the divide
                if (state_reg == ST_DIV) begin
                    cnt_next = cnt_reg + 1'b1;
                    if (t_reg != '0) begin
                        clog_next = clog_reg + 1'b1;
                        t_next    = t_reg >> 1;
                    end
                end
            end
            ST_TEST: begin
                if (!loop_done) begin
                    if (!have_down_reg && r_le) begin
                        have_down_next = 1'b1;
                        down_mul_next  = q_reg;
                        down_exp_next  = e_reg;
                    end
                    e_next     = e_reg + 1'b1;
                    s_next     = s_reg + 1'b1;
                    hmask_next = hmask_reg << 1;
                end
            end
            ST_FINISH: begin
                if (out_wr) begin
                    m_multiplier_next     = '0;
                    m_dividend_shift_next = '0;
                    m_product_shift_next  = '0;
                    m_add_increment_next  = 1'b0;
                    m_bad_divisor_next    = 1'b1;
                    if (!bad_reg) begin
                        if (up_ok) begin
                            m_multiplier_next     = 32'(alu_sum[W-1:0]);
                            m_dividend_shift_next = 5'(pre_reg);
                            m_product_shift_next  = 5'(e_reg);
                            m_bad_divisor_next    = 1'b0;
                        end else if (have_down_reg) begin
                            // round-down multiplier with saturating increment
                            m_multiplier_next     = 32'(down_mul_reg);
                            m_dividend_shift_next = 5'(pre_reg);
                            m_product_shift_next  = 5'(down_exp_reg);
                            m_add_increment_next  = 1'b1;
                            m_bad_divisor_next    = 1'b0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_wr) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        d_reg                <= d_next;
        bits_reg             <= bits_next;
        pre_reg              <= pre_next;
        q_reg                <= q_next;
        r_reg                <= r_next;
        t_reg                <= t_next;
        clog_reg             <= clog_next;
        cnt_reg              <= cnt_next;
        e_reg                <= e_next;
        s_reg                <= s_next;
        hmask_reg            <= hmask_next;
        down_mul_reg         <= down_mul_next;
        down_exp_reg         <= down_exp_next;
        have_down_reg        <= have_down_next;
        bad_reg              <= bad_next;
        m_multiplier_reg     <= m_multiplier_next;
        m_dividend_shift_reg <= m_dividend_shift_next;
        m_product_shift_reg  <= m_product_shift_next;
        m_add_increment_reg  <= m_add_increment_next;
        m_bad_divisor_reg    <= m_bad_divisor_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_multiplier     = m_multiplier_reg;
    assign m_dividend_shift = m_dividend_shift_reg;
    assign m_product_shift  = m_product_shift_reg;
    assign m_add_increment  = m_add_increment_reg;
    assign m_bad_divisor    = m_bad_divisor_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/udm_checker.sv =====
// ----------------------------------------------------------------------------
// udm_checker
// Port-level checks for the unsigned division magic generator, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module udm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [31:0] s_divisor,
    input wire logic [5:0]  s_dividend_bits,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_multiplier,
    input wire logic [4:0]  m_dividend_shift,
    input wire logic [4:0]  m_product_shift,
    input wire logic        m_add_increment,
    input wire logic        m_bad_divisor
);

    // one word at a time: taking a word closes the input side
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken again right after a word");

    // no result can appear in the cycle after a word is taken
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result raised too early");

    // an error result carries an all-zero recipe
    a_bad_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bad_divisor) |-> (m_multiplier == 32'd0) && (m_dividend_shift == 5'd0)
            && (m_product_shift == 5'd0) && !m_add_increment)
        else $error("error result with nonzero fields");

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_multiplier)
            && $stable(m_dividend_shift) && $stable(m_product_shift)
            && $stable(m_add_increment) && $stable(m_bad_divisor))
        else $error("stalled result word changed");

    // input word fields are only observed through the bind
    logic unused_in;
    assign unused_in = ^{s_divisor, s_dividend_bits};

endmodule

bind unsigned_division_magic_generator udm_checker u_udm_checker (.*);

`default_nettype wire
